// ----- src/key_event_history_ring_core_defines.svh -----
// ----------------------------------------------------------------------------
// Key-event history ring: assertion macros
// Shared assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KEY_EVENT_HISTORY_RING_CORE_DEFINES_SVH
`define KEY_EVENT_HISTORY_RING_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KEHR_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kehr assertion failed");
// next-cycle implication
`define KEHR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kehr assertion failed");
`else
`define KEHR_ASSERT(lbl, clk, rstn, ante, cons)
`define KEHR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/kehr_pkg.sv -----
// ----------------------------------------------------------------------------
// Key-event history ring package
// Sizes, command and entry-kind codes, and the request/response records.
// ----------------------------------------------------------------------------
package kehr_pkg;

  // ring geometry (DEPTH must be a power of two)
  localparam int unsigned DEPTH   = 32;
  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  // attach search span
  localparam int unsigned SPAN    = 4;
  localparam int unsigned PROBE_W = $clog2(SPAN + 1);

  localparam logic [8:0] POS_NONE = 9'd256;

  typedef enum logic [1:0] {
    CMD_POS   = 2'd0,
    CMD_LAYER = 2'd1,
    CMD_KEY   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LAYER   = 2'd2
  } kind_e;

  // stored metadata; layer entries keep new layer in pos[4:0], on/off in pos[5]
  typedef struct packed {
    logic [7:0] mods;
    logic [8:0] pos;
    logic [4:0] layer;
    kind_e      kind;
  } meta_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] code;
    meta_t       meta;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    cmd_e        cmd;
    logic        pressed;
    logic [7:0]  key_position;
    logic [4:0]  current_layer;
    logic [4:0]  changed_layer;
    logic        layer_on;
    logic [31:0] key_code;
    logic [7:0]  modifiers;
    logic [31:0] time_ms;
    logic [7:0]  read_offset;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  entry_kind;
    logic [4:0]  entry_layer;
    logic [8:0]  entry_position;
    logic [31:0] entry_keycode;
    logic [7:0]  entry_mods;
    logic [4:0]  entry_new_layer;
    logic        entry_layer_on;
    logic [31:0] entry_time;
    logic [8:0]  entry_count;
  } rsp_t;

endpackage

// ----- src/kehr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kehr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/kehr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Key-event history ring sequencer
// Ring pointers, append, attach search over the newest entries, and reads.
// ----------------------------------------------------------------------------
`include "key_event_history_ring_core_defines.svh"

module kehr_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,
  input  logic                               req_valid_i,
  output logic                               req_ready_o,
  input  kehr_pkg::req_t                     req_i,
  output logic                               rsp_valid_o,
  input  logic                               rsp_ready_i,
  output kehr_pkg::rsp_t                     rsp_o,
  output logic                               ram_wr_en_o,
  output logic [kehr_pkg::SLOT_W-1:0]        ram_wr_addr_o,
  output kehr_pkg::entry_t                   ram_wr_data_o,
  output logic                               ram_rd_en_o,
  output logic [kehr_pkg::SLOT_W-1:0]        ram_rd_addr_o,
  input  kehr_pkg::entry_t                   ram_rd_data_i
);
  import kehr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SRCH = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic                recording_q;
  logic [SLOT_W-1:0]   wslot_q, wslot_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [PROBE_W-1:0]  probe_q, probe_d;
  logic [SLOT_W-1:0]   pslot_q, pslot_d;
  logic                found_q, found_d;
  logic [4:0]          layer_q;
  logic [31:0]         code_q;
  logic [7:0]          mods_q;
  logic [31:0]         time_q;

  logic                accept;
  logic                push;
  logic [PROBE_W-1:0]  probe_nxt;
  entry_t              hit;

  // standalone press, no key position
  function automatic entry_t make_solo(input logic [4:0] lay, input logic [7:0] md,
                                       input logic [31:0] cd, input logic [31:0] ts);
    entry_t e;
    e.meta.kind  = KIND_PRESS;
    e.meta.layer = lay;
    e.meta.pos   = POS_NONE;
    e.meta.mods  = md;
    e.code       = cd;
    e.stamp      = ts;
    return e;
  endfunction

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign probe_nxt   = probe_q + 1'b1;
  assign rsp_valid_o = (state_q == ST_READ);

  // sequencer
  always_comb begin
    state_d       = state_q;
    probe_d       = probe_q;
    pslot_d       = pslot_q;
    found_d       = found_q;
    push          = 1'b0;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = wslot_q;
    ram_wr_data_o = '0;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = wslot_q - 1'b1;
    hit           = ram_rd_data_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.cmd)
            CMD_READ: begin
              found_d       = {1'b0, req_i.read_offset} < 9'(count_q);
              ram_rd_en_o   = 1'b1;
              ram_rd_addr_o = wslot_q - 1'b1 - req_i.read_offset[SLOT_W-1:0];
              state_d       = ST_READ;
            end
            CMD_POS: begin
              if (recording_q) begin
                ram_wr_en_o              = 1'b1;
                ram_wr_data_o.meta.kind  = req_i.pressed ? KIND_PRESS : KIND_RELEASE;
                ram_wr_data_o.meta.layer = req_i.current_layer;
                ram_wr_data_o.meta.pos   = {1'b0, req_i.key_position};
                ram_wr_data_o.stamp      = req_i.time_ms;
                push                     = 1'b1;
              end
            end
            CMD_LAYER: begin
              if (recording_q) begin
                ram_wr_en_o              = 1'b1;
                ram_wr_data_o.meta.kind  = KIND_LAYER;
                ram_wr_data_o.meta.layer = req_i.current_layer;
                ram_wr_data_o.meta.pos   = {3'b000, req_i.layer_on, req_i.changed_layer};
                ram_wr_data_o.stamp      = req_i.time_ms;
                push                     = 1'b1;
              end
            end
            CMD_KEY: begin
              if (recording_q && req_i.pressed) begin
                if (count_q == '0) begin
                  // empty ring: nothing to attach to
                  ram_wr_en_o   = 1'b1;
                  ram_wr_data_o = make_solo(req_i.current_layer, req_i.modifiers,
                                            req_i.key_code, req_i.time_ms);
                  push          = 1'b1;
                end else begin
                  ram_rd_en_o   = 1'b1;
                  ram_rd_addr_o = wslot_q - 1'b1;
                  pslot_d       = wslot_q - 1'b1;
                  probe_d       = '0;
                  state_d       = ST_SRCH;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SRCH: begin
        if (ram_rd_data_i.meta.kind == KIND_PRESS && ram_rd_data_i.code == '0) begin
          // attach keycode and mods to the unresolved press
          hit.code      = code_q;
          hit.meta.mods = mods_q;
          ram_wr_en_o   = 1'b1;
          ram_wr_addr_o = pslot_q;
          ram_wr_data_o = hit;
          state_d       = ST_IDLE;
        end else if (probe_nxt < PROBE_W'(SPAN) && CNT_W'(probe_nxt) < count_q) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = wslot_q - 1'b1 - SLOT_W'(probe_nxt);
          pslot_d       = wslot_q - 1'b1 - SLOT_W'(probe_nxt);
          probe_d       = probe_nxt;
        end else begin
          ram_wr_en_o   = 1'b1;
          ram_wr_data_o = make_solo(layer_q, mods_q, code_q, time_q);
          push          = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      ST_READ: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ring pointer and fill count
  always_comb begin
    wslot_d = wslot_q;
    count_d = count_q;
    if (push) begin
      wslot_d = wslot_q + 1'b1;
      if (count_q != CNT_W'(DEPTH)) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // response fields from the entry just read
  always_comb begin
    rsp_o             = '0;
    rsp_o.entry_count = 9'(count_q);
    if (found_q) begin
      rsp_o.found       = 1'b1;
      rsp_o.entry_kind  = ram_rd_data_i.meta.kind;
      rsp_o.entry_layer = ram_rd_data_i.meta.layer;
      rsp_o.entry_time  = ram_rd_data_i.stamp;
      if (ram_rd_data_i.meta.kind == KIND_LAYER) begin
        rsp_o.entry_new_layer = ram_rd_data_i.meta.pos[4:0];
        rsp_o.entry_layer_on  = ram_rd_data_i.meta.pos[5];
      end else begin
        rsp_o.entry_position = ram_rd_data_i.meta.pos;
        rsp_o.entry_keycode  = ram_rd_data_i.code;
        rsp_o.entry_mods     = ram_rd_data_i.meta.mods;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      recording_q <= 1'b1;
      wslot_q     <= '0;
      count_q     <= '0;
      probe_q     <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      wslot_q <= wslot_d;
      count_q <= count_d;
      probe_q <= probe_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        recording_q <= cfg_wdata_i;
      end
    end
  end

  // event payload kept for the search
  always_ff @(posedge clk_i) begin
    pslot_q <= pslot_d;
    if (accept) begin
      layer_q <= req_i.current_layer;
      code_q  <= req_i.key_code;
      mods_q  <= req_i.modifiers;
      time_q  <= req_i.time_ms;
    end
  end

  // checks
  `KEHR_ASSERT(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH))
  `KEHR_ASSERT(a_probe_range, clk_i, rst_ni, state_q == ST_SRCH, (probe_q < PROBE_W'(SPAN)) && (CNT_W'(probe_q) < count_q))
  `KEHR_ASSERT(a_no_wr_on_read, clk_i, rst_ni, state_q == ST_READ, !ram_wr_en_o && !push)
  `KEHR_ASSERT_NXT(a_push_grows, clk_i, rst_ni, push && (count_q != CNT_W'(DEPTH)), count_q == $past(count_q) + 1'b1)

endmodule

// ----- src/key_event_history_ring_core.sv -----
// A read result reaches m_axis via the RAM read register and the output register.
// Requests are taken only while the sequencer is idle. Position, layer and ignored
// events end on acceptance; a read waits for the output register to take its result;
// a keycode press is stored at once on an empty ring, else the ring RAM is probed one
// entry at a time over the newest 4 entries. Reset clears the ring pointer and entry
// count and sets recording on; the entry RAM is not cleared. Ready out of reset.
// ----------------------------------------------------------------------------
// Key-event history ring core
// Stream wrapper: request unpacking, entry RAM, sequencer and output register.
// ----------------------------------------------------------------------------
module key_event_history_ring_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // pressed[0], key_position[8:1], current_layer[13:9], changed_layer[18:14],
  // layer_on[19], key_code[51:20], modifiers[59:52], time_ms[91:60],
  // read_offset[99:92], zero fill [103:100]
  input  logic [103:0]  s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // entry_layer[4:0], entry_position[13:5], entry_keycode[45:14],
  // entry_mods[53:46], entry_new_layer[58:54], entry_layer_on[59],
  // entry_time[91:60], entry_count[100:92], zero fill [103:101]
  output logic [103:0]  m_axis_tdata_o,
  // found[0], entry_kind[2:1]
  output logic [2:0]    m_axis_tuser_o
);
  import kehr_pkg::*;

  req_t              req;
  rsp_t              rsp;
  logic              rsp_valid;
  logic              rsp_ready;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              m_valid_q;
  rsp_t              m_data_q;

  // request unpacking
  assign req.cmd           = cmd_e'(s_axis_tuser_i);
  assign req.pressed       = s_axis_tdata_i[0];
  assign req.key_position  = s_axis_tdata_i[8:1];
  assign req.current_layer = s_axis_tdata_i[13:9];
  assign req.changed_layer = s_axis_tdata_i[18:14];
  assign req.layer_on      = s_axis_tdata_i[19];
  assign req.key_code      = s_axis_tdata_i[51:20];
  assign req.modifiers     = s_axis_tdata_i[59:52];
  assign req.time_ms       = s_axis_tdata_i[91:60];
  assign req.read_offset   = s_axis_tdata_i[99:92];

  kehr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_valid_i   (s_axis_tvalid_i),
    .req_ready_o   (s_axis_tready_o),
    .req_i         (req),
    .rsp_valid_o   (rsp_valid),
    .rsp_ready_i   (rsp_ready),
    .rsp_o         (rsp),
    .ram_wr_en_o   (wr_en),
    .ram_wr_addr_o (wr_addr),
    .ram_wr_data_o (wr_data),
    .ram_rd_en_o   (rd_en),
    .ram_rd_addr_o (rd_addr),
    .ram_rd_data_i (rd_data)
  );

  kehr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // output register
  assign rsp_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      m_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      m_data_q <= rsp;
    end
  end

  // result packing
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = {m_data_q.entry_kind, m_data_q.found};
  assign m_axis_tdata_o  = {3'b000,
                            m_data_q.entry_count,
                            m_data_q.entry_time,
                            m_data_q.entry_layer_on,
                            m_data_q.entry_new_layer,
                            m_data_q.entry_mods,
                            m_data_q.entry_keycode,
                            m_data_q.entry_position,
                            m_data_q.entry_layer};

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Key-event history ring: stream-level testbench
// Drives event and read requests, checks read results field by field against
// a local copy of the ring or fixed directed values, with random stalls.
// ----------------------------------------------------------------------------
module testbench;
  import kehr_pkg::*;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we;
  logic          cfg_wdata;
  logic          s_tvalid;
  logic          s_tready;
  // pressed, key_position, current_layer, changed_layer, layer_on, key_code,
  // modifiers, time_ms, read_offset, zero fill
  logic [103:0]  s_tdata;
  // cmd
  logic [1:0]    s_tuser;
  logic          m_tvalid;
  logic          m_tready;
  // entry_layer, entry_position, entry_keycode, entry_mods, entry_new_layer,
  // entry_layer_on, entry_time, entry_count, zero fill
  logic [103:0]  m_tdata;
  // found, entry_kind
  logic [2:0]    m_tuser;

  key_event_history_ring_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // one stored history entry, unpacked
  typedef struct {
    kind_e       kind;
    logic [4:0]  layer;
    logic [8:0]  pos;
    logic [31:0] code;
    logic [7:0]  mods;
    logic [4:0]  chg_layer;
    logic        layer_on;
    logic [31:0] stamp;
  } hist_t;

  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  hist_t       hist [DEPTH];
  int unsigned head;
  int unsigned fill;
  bit          rec_on;

  rsp_t        read_rsp_q [$];
  dir_row_t    dir_tbl [$];

  int          n_mismatch;
  int          n_results;
  int          n_requests;
  int          n_dropped;
  bit          tx_calm;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // hard stop
  initial begin
    #5000000;
    $display("timeout: requests %0d, results pending %0d", n_requests, read_rsp_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void hist_push(input hist_t e);
    hist[head] = e;
    head = (head + 1) % DEPTH;
    if (fill < DEPTH) fill++;
  endfunction

  // returns 1 when the request yields a read result
  function automatic bit ring_predict(input req_t rq, output rsp_t r);
    hist_t       e;
    int unsigned s;
    r = '0;
    e.kind      = KIND_PRESS;
    e.layer     = rq.current_layer;
    e.pos       = '0;
    e.code      = '0;
    e.mods      = '0;
    e.chg_layer = '0;
    e.layer_on  = 1'b0;
    e.stamp     = rq.time_ms;

    // reads are served whatever the recording state
    if (rq.cmd == CMD_READ) begin
      r.entry_count = fill[8:0];
      if (rq.read_offset < fill) begin
        s = (head + DEPTH - 1 - rq.read_offset) % DEPTH;
        r.found       = 1'b1;
        r.entry_kind  = hist[s].kind;
        r.entry_layer = hist[s].layer;
        if (hist[s].kind == KIND_LAYER) begin
          r.entry_new_layer = hist[s].chg_layer;
          r.entry_layer_on  = hist[s].layer_on;
        end else begin
          r.entry_position = hist[s].pos;
          r.entry_keycode  = hist[s].code;
          r.entry_mods     = hist[s].mods;
        end
        r.entry_time = hist[s].stamp;
      end
      return 1'b1;
    end

    if (!rec_on || (rq.cmd == CMD_KEY && !rq.pressed)) begin
      n_dropped++;
      return 1'b0;
    end

    case (rq.cmd)
      CMD_POS: begin
        e.kind = rq.pressed ? KIND_PRESS : KIND_RELEASE;
        e.pos  = {1'b0, rq.key_position};
        hist_push(e);
      end
      CMD_LAYER: begin
        e.kind      = KIND_LAYER;
        e.chg_layer = rq.changed_layer;
        e.layer_on  = rq.layer_on;
        hist_push(e);
      end
      default: begin
        // attach to the newest unresolved press within the search span
        for (int i = 0; i < fill && i < SPAN; i++) begin
          s = (head + DEPTH - 1 - i) % DEPTH;
          if (hist[s].kind == KIND_PRESS && hist[s].code == '0) begin
            hist[s].code = rq.key_code;
            hist[s].mods = rq.modifiers;
            return 1'b0;
          end
        end
        // no match: standalone press without a position
        e.pos  = POS_NONE;
        e.code = rq.key_code;
        e.mods = rq.modifiers;
        hist_push(e);
      end
    endcase
    return 1'b0;
  endfunction

  // ------------------------------------------------------------------ checker
  function automatic void field_diff(input string nm, input logic [31:0] got,
                                     input logic [31:0] want);
    if (got !== want) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch on %s: expected %0h, got %0h", nm, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_mon
    rsp_t got;
    rsp_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tuser[2:1], m_tdata[4:0], m_tdata[13:5], m_tdata[45:14],
             m_tdata[53:46], m_tdata[58:54], m_tdata[59], m_tdata[91:60],
             m_tdata[100:92]};
      n_results++;
      if (read_rsp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: %h", got);
      end else begin
        want = read_rsp_q.pop_front();
        field_diff("found", got.found, want.found);
        field_diff("entry_kind", got.entry_kind, want.entry_kind);
        field_diff("entry_layer", got.entry_layer, want.entry_layer);
        field_diff("entry_position", got.entry_position, want.entry_position);
        field_diff("entry_keycode", got.entry_keycode, want.entry_keycode);
        field_diff("entry_mods", got.entry_mods, want.entry_mods);
        field_diff("entry_new_layer", got.entry_new_layer, want.entry_new_layer);
        field_diff("entry_layer_on", got.entry_layer_on, want.entry_layer_on);
        field_diff("entry_time", got.entry_time, want.entry_time);
        field_diff("entry_count", got.entry_count, want.entry_count);
      end
    end
  end

  // result side: random stalls with quiet stretches
  initial begin : result_sink
    int stall;
    bit rx_calm;
    rx_calm = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
    end
  end

  // ------------------------------------------------------------ request side
  task automatic send_req(input req_t rq, output bit has_rsp, output rsp_t r);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= {4'b0, rq.read_offset, rq.time_ms, rq.modifiers, rq.key_code,
                 rq.layer_on, rq.changed_layer, rq.current_layer, rq.key_position,
                 rq.pressed};
    s_tuser  <= rq.cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    n_requests++;
    has_rsp = ring_predict(rq, r);
  endtask

  // hold requests until every read result is back and the sequencer is idle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (read_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_recording(input bit v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    rec_on = v;
  endtask

  function automatic void add_row(input req_t rq, input bit typed = 1'b0,
                                  input rsp_t want = '0);
    dir_row_t row;
    row.rq    = rq;
    row.typed = typed;
    row.want  = want;
    dir_tbl.push_back(row);
  endfunction

  function automatic rsp_t not_found(input int unsigned cnt);
    rsp_t r;
    r = '0;
    r.entry_count = cnt[8:0];
    return r;
  endfunction

  // mostly key strokes (press, keycode attach, release) with reads mixed in
  task automatic run_phase(input int n);
    req_t rq;
    rsp_t r;
    bit   has_rsp;
    int   pick;
    for (int k = 0; k < n; k++) begin
      rq.pressed       = $urandom_range(0, 1);
      rq.key_position  = $urandom_range(0, 255);
      rq.current_layer = $urandom_range(0, 31);
      rq.changed_layer = $urandom_range(0, 31);
      rq.layer_on      = $urandom_range(0, 1);
      rq.key_code      = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
      rq.modifiers     = $urandom_range(0, 255);
      rq.time_ms       = $urandom;
      rq.read_offset   = $urandom_range(0, 255);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        rq.cmd = CMD_POS;
        rq.pressed = 1'b1;
      end else if (pick < 45) begin
        rq.cmd = CMD_KEY;
        rq.pressed = 1'b1;
      end else if (pick < 50) begin
        rq.cmd = CMD_KEY;
        rq.pressed = 1'b0;
      end else if (pick < 65) begin
        rq.cmd = CMD_POS;
        rq.pressed = 1'b0;
      end else if (pick < 72) begin
        rq.cmd = CMD_LAYER;
      end else begin
        rq.cmd = CMD_READ;
        // most reads land on held entries
        if ($urandom_range(0, 9) < 7)
          rq.read_offset = $urandom_range(0, (fill == 0) ? 0 : fill - 1);
      end
      send_req(rq, has_rsp, r);
      if (has_rsp) read_rsp_q.push_back(r);
      if (k % 300 == 299) drain();
    end
  endtask

  // --------------------------------------------------------------------- main
  initial begin : main_seq
    rsp_t r;
    bit   has_rsp;
    n_mismatch = 0;
    n_results  = 0;
    n_requests = 0;
    n_dropped  = 0;
    tx_calm    = 1'b0;
    head       = 0;
    fill       = 0;
    rec_on     = 1'b1;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_POS;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_recording(1'b1);

    // directed: empty ring, extremes, keycode attach rules, layer entries
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd0},
            1'b1, not_found(0));
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd255},
            1'b1, not_found(0));
    // keycode release is dropped
    add_row(req_t'{CMD_KEY, 1'b0, 8'h00, 5'd3, 5'd0, 1'b0, 32'h1234, 8'h01, 32'h5, 8'd0});
    // keycode press on an empty ring: standalone press
    add_row(req_t'{CMD_KEY, 1'b1, 8'h00, 5'd31, 5'd0, 1'b0, 32'hFFFF_FFFF, 8'hFF,
                   32'hFFFF_FFFF, 8'd0});
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd0},
            1'b1, rsp_t'{1'b1, KIND_PRESS, 5'd31, POS_NONE, 32'hFFFF_FFFF, 8'hFF, 5'd0,
                         1'b0, 32'hFFFF_FFFF, 9'd1});
    add_row(req_t'{CMD_POS, 1'b1, 8'hFF, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd0});
    // keycode 0 attached leaves the press open for the next keycode
    add_row(req_t'{CMD_KEY, 1'b1, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h5A, 32'h2, 8'd0});
    add_row(req_t'{CMD_KEY, 1'b1, 8'h00, 5'd0, 5'd0, 1'b0, 32'hDEAD_BEEF, 8'h81, 32'h3,
                   8'd0});
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd0});
    add_row(req_t'{CMD_POS, 1'b0, 8'h00, 5'd31, 5'd0, 1'b0, 32'h0, 8'h00, 32'h1, 8'd0});
    add_row(req_t'{CMD_LAYER, 1'b0, 8'h00, 5'd31, 5'd31, 1'b1, 32'h0, 8'h00, 32'h10, 8'd0});
    add_row(req_t'{CMD_LAYER, 1'b1, 8'hFF, 5'd0, 5'd0, 1'b0, 32'hFFFF_FFFF, 8'hFF, 32'h11,
                   8'd0});
    add_row(req_t'{CMD_POS, 1'b1, 8'h55, 5'd10, 5'd0, 1'b0, 32'h0, 8'h00, 32'h20, 8'd0});
    add_row(req_t'{CMD_POS, 1'b1, 8'hAA, 5'd21, 5'd0, 1'b0, 32'h0, 8'h00, 32'h21, 8'd0});
    // newest open press takes the keycode, the older one the next
    add_row(req_t'{CMD_KEY, 1'b1, 8'h00, 5'd0, 5'd0, 1'b0, 32'h7, 8'h02, 32'h22, 8'd0});
    add_row(req_t'{CMD_KEY, 1'b1, 8'h00, 5'd0, 5'd0, 1'b0, 32'h9, 8'h40, 32'h23, 8'd0});
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd0});
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd1});
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd2});
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd3});
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd4});
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd6});
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd7},
            1'b1, not_found(7));
    add_row(req_t'{CMD_READ, 1'b0, 8'h00, 5'd0, 5'd0, 1'b0, 32'h0, 8'h00, 32'h0, 8'd255},
            1'b1, not_found(7));

    foreach (dir_tbl[i]) begin
      send_req(dir_tbl[i].rq, has_rsp, r);
      if (has_rsp) read_rsp_q.push_back(dir_tbl[i].typed ? dir_tbl[i].want : r);
    end

    // random phases across both recording settings
    run_phase(900);
    set_recording(1'b0);
    run_phase(200);
    set_recording(1'b1);
    run_phase(900);
    set_recording(1'b0);
    run_phase(60);
    s_tvalid <= 1'b0;

    // wind down
    for (int k = 0; k < 2000 && read_rsp_q.size() != 0; k++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (read_rsp_q.size() != 0) begin
      $display("%0d read results never arrived", read_rsp_q.size());
      n_mismatch += read_rsp_q.size();
    end

    $display("ran %0d requests; %0d read results compared", n_requests, n_results);
    $display("%0d events dropped (recording off or key release); %0d mismatches",
             n_dropped, n_mismatch);
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
